@@ rtl/core/psm_pkg.sv @@
// ----------------------------------------------------------------------------
// psm_pkg
// Shared types and sizes for the pattern sample mixer.
// ----------------------------------------------------------------------------
package psm_pkg;

  localparam int LAYERS           = 8;
  localparam int BLOCKS_PER_LAYER = 16;
  localparam int SAMPLE_DEPTH     = 65536;

  localparam int LAYER_W   = (LAYERS > 1) ? $clog2(LAYERS) : 1;
  localparam int BLK_W     = (BLOCKS_PER_LAYER > 1) ? $clog2(BLOCKS_PER_LAYER) : 1;
  localparam int SAMPLE_AW = $clog2(SAMPLE_DEPTH);
  localparam int ENTRY_W   = LAYER_W + BLK_W;
  localparam int ENTRIES   = 1 << ENTRY_W;
  localparam int SRAM_AW   = LAYER_W + SAMPLE_AW;
  localparam int SRAM_D    = 1 << SRAM_AW;

  localparam int FC_W   = 37;
  localparam int BASE_W = FC_W + 2;
  localparam int ACC_W  = 16 + ENTRY_W + 1;

  localparam logic [23:0] FPB_RESET  = 24'd88200;
  localparam logic [12:0] BARS_RESET = 13'd64;
  localparam logic [12:0] BARS_ZERO  = 13'd64;

  // Request codes
  localparam logic [2:0] REQ_TICK    = 3'd0;
  localparam logic [2:0] REQ_SAMPLE  = 3'd1;
  localparam logic [2:0] REQ_BLOCK   = 3'd2;
  localparam logic [2:0] REQ_LAYER   = 3'd3;
  localparam logic [2:0] REQ_RESTART = 3'd4;

  // Register indexes on the config port
  localparam logic REG_FPB  = 1'b0;
  localparam logic REG_BARS = 1'b1;

  typedef struct packed {
    logic [2:0]         req_type;
    logic [2:0]         layer;
    logic [15:0]        address;
    logic signed [15:0] sample_value;
    logic [11:0]        block_start;
    logic [11:0]        block_length;
    logic               block_enable;
    logic [16:0]        layer_words;
    logic [1:0]         layer_channels;
  } req_t;

  typedef struct packed {
    logic signed [15:0] left_sample;
    logic signed [15:0] right_sample;
    logic               frame_valid;
    logic               done_res;
  } res_t;

  typedef struct packed {
    logic [11:0] start;
    logic [11:0] length;
    logic        enable;
  } blk_t;

endpackage

@@ rtl/core/pattern_sample_mixer_core.sv @@
// ----------------------------------------------------------------------------
// pattern_sample_mixer_core
// Frame sequencer and mixer. Requests load sample words, pattern blocks and
// layer info, restart playback, or tick one stereo frame. On a tick the block
// table memory is swept one entry per cycle through a six-stage pipeline,
// with both channel words of a hit read from the sample memory in the same
// cycle. A tick past the end of playback skips the sweep. A new request is
// taken while the previous result still waits on the result channel.
// ----------------------------------------------------------------------------
module pattern_sample_mixer_core
  import psm_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  // request channel
  input  logic        req_valid,
  output logic        req_ready,
  input  req_t        req_data,
  // result channel
  output logic        res_valid,
  input  logic        res_ready,
  output res_t        res_data,
  // config port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  typedef enum logic [2:0] {
    S_IDLE, S_LIMIT, S_CHECK, S_SWEEP, S_RESP
  } state_t;

  function automatic logic signed [15:0] sat16(input logic signed [ACC_W-1:0] v);
    logic signed [15:0] r;
    if (v > ACC_W'(32767)) begin
      r = 16'sh7fff;
    end else if (v < -ACC_W'(32768)) begin
      r = -16'sh8000;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

  state_t state;
  logic [23:0] fpb;
  logic [12:0] total_bars;
  logic [FC_W-1:0] frame_count;
  logic [FC_W-1:0] limit;
  logic finished;
  res_t pend;
  logic [ENTRY_W:0] cnt;

  logic [16:0] lwords [LAYERS];
  logic [1:0]  lchans [LAYERS];
  logic [ENTRIES-1:0] blk_valid;

  logic accept;
  logic load_res;
  logic blk_we, sram_we;
  logic [ENTRY_W-1:0] blk_waddr;
  logic [SRAM_AW-1:0] sram_waddr;
  blk_t blk_wdata, blk_rdata;
  logic [SRAM_AW-1:0] sram_raddr_a, sram_raddr_b;
  logic signed [15:0] sram_rdata_a, sram_rdata_b;
  logic [24:0] blk_unused;

  // sweep pipeline
  logic vb, vc, vd, ve, vf;
  logic [ENTRY_W-1:0] eb;
  logic [LAYER_W-1:0] ly_c, ly_d, ly_e;
  logic [16:0] words_c, words_d, words_e;
  logic [1:0] chans_c, chans_d, chans_e;
  logic [FC_W-1:0] s_c, e_c, off_d;
  logic [BASE_W-1:0] base_e, idx1;
  logic en0_f, en1_f;
  logic signed [ACC_W-1:0] acc_l, acc_r;
  logic [LAYER_W-1:0] ly_b;
  logic act_b;
  logic issue_done;

  assign accept    = req_valid && req_ready;
  assign req_ready = (state == S_IDLE);
  assign pready    = 1'b1;
  assign prdata    = (paddr[2] == REG_BARS) ? 32'(total_bars) : 32'(fpb);

  // Load the result register when it is empty or being drained
  assign load_res  = (state == S_RESP) && (!res_valid || res_ready);

  // Write ports of the two memories
  assign sram_we    = accept && req_data.req_type == REQ_SAMPLE
                      && 32'(req_data.layer) < LAYERS
                      && 32'(req_data.address) < SAMPLE_DEPTH;
  assign sram_waddr = {LAYER_W'(req_data.layer), SAMPLE_AW'(req_data.address)};
  assign blk_we     = accept && req_data.req_type == REQ_BLOCK
                      && 32'(req_data.layer) < LAYERS
                      && 32'(req_data.address) < BLOCKS_PER_LAYER;
  assign blk_waddr  = {LAYER_W'(req_data.layer), BLK_W'(req_data.address)};
  assign blk_wdata  = '{start: req_data.block_start, length: req_data.block_length,
                        enable: req_data.block_enable};

  psm_ram #(.WIDTH(16), .DEPTH(SRAM_D)) u_sample_ram (
    .clk     (clk),
    .we      (sram_we),
    .waddr   (sram_waddr),
    .wdata   (req_data.sample_value),
    .raddr_a (sram_raddr_a),
    .rdata_a (sram_rdata_a),
    .raddr_b (sram_raddr_b),
    .rdata_b (sram_rdata_b)
  );

  psm_ram #(.WIDTH(25), .DEPTH(ENTRIES)) u_block_ram (
    .clk     (clk),
    .we      (blk_we),
    .waddr   (blk_waddr),
    .wdata   (blk_wdata),
    .raddr_a (cnt[ENTRY_W-1:0]),
    .rdata_a (blk_rdata),
    .raddr_b (cnt[ENTRY_W-1:0]),
    .rdata_b (blk_unused)
  );

  assign issue_done = (cnt == (ENTRY_W+1)'(ENTRIES));

  // Stage B decode: an entry never written reads as disabled
  assign ly_b  = eb[ENTRY_W-1:BLK_W];
  assign act_b = blk_valid[eb] && blk_rdata.enable && (lwords[ly_b] != '0);

  // Stage E sample addresses
  assign idx1         = base_e + BASE_W'(1);
  assign sram_raddr_a = {ly_e, base_e[SAMPLE_AW-1:0]};
  assign sram_raddr_b = {ly_e, idx1[SAMPLE_AW-1:0]};

  // Config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      fpb        <= FPB_RESET;
      total_bars <= BARS_RESET;
    end else if (psel && penable && pwrite && pready) begin
      if (paddr[2] == REG_FPB) begin
        fpb <= pwdata[23:0];
      end else begin
        total_bars <= pwdata[12:0];
      end
    end
  end

  // Layer info and block valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      blk_valid <= '0;
      for (int i = 0; i < LAYERS; i++) begin
        lwords[i] <= '0;
        lchans[i] <= 2'd1;
      end
    end else begin
      if (blk_we) begin
        blk_valid[blk_waddr] <= 1'b1;
      end
      if (accept && req_data.req_type == REQ_LAYER && 32'(req_data.layer) < LAYERS) begin
        lwords[LAYER_W'(req_data.layer)] <=
          (32'(req_data.layer_words) > SAMPLE_DEPTH) ? 17'(SAMPLE_DEPTH)
                                                     : req_data.layer_words;
        lchans[LAYER_W'(req_data.layer)] <=
          (req_data.layer_channels == 2'd0) ? 2'd1 : req_data.layer_channels;
      end
    end
  end

  // Sweep pipeline: block read, window products, hit test, word offset,
  // sample read, accumulate
  always_ff @(posedge clk) begin
    if (rst) begin
      vb <= 1'b0;
      vc <= 1'b0;
      vd <= 1'b0;
      ve <= 1'b0;
      vf <= 1'b0;
    end else begin
      vb <= (state == S_SWEEP) && !issue_done;
      vc <= vb && act_b;
      vd <= vc && frame_count >= s_c && frame_count < e_c;
      ve <= vd;
      vf <= ve;
    end
    eb      <= cnt[ENTRY_W-1:0];
    s_c     <= FC_W'(blk_rdata.start) * FC_W'(fpb);
    e_c     <= (FC_W'(blk_rdata.start) + FC_W'(blk_rdata.length)) * FC_W'(fpb);
    ly_c    <= ly_b;
    words_c <= lwords[ly_b];
    chans_c <= lchans[ly_b];
    off_d   <= frame_count - s_c;
    ly_d    <= ly_c;
    words_d <= words_c;
    chans_d <= chans_c;
    case (chans_d)
      2'd2:    base_e <= {off_d, 1'b0} + BASE_W'(0);
      2'd3:    base_e <= BASE_W'({off_d, 1'b0}) + BASE_W'(off_d);
      default: base_e <= BASE_W'(off_d);
    endcase
    ly_e    <= ly_d;
    words_e <= words_d;
    chans_e <= chans_d;
    en0_f   <= base_e < BASE_W'(words_e);
    en1_f   <= chans_e >= 2'd2 && idx1 < BASE_W'(words_e);
  end

  // Control: request decode, sweep count, frame position, result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      frame_count <= '0;
      finished    <= 1'b0;
      cnt         <= '0;
      res_valid   <= 1'b0;
    end else begin
      if (load_res) begin
        res_valid <= 1'b1;
      end else if (res_valid && res_ready) begin
        res_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            pend <= '{left_sample: '0, right_sample: '0, frame_valid: 1'b0,
                      done_res: (req_data.req_type == REQ_RESTART) ? 1'b0 : finished};
            if (req_data.req_type == REQ_TICK) begin
              state <= S_LIMIT;
            end else begin
              if (req_data.req_type == REQ_RESTART) begin
                frame_count <= '0;
                finished    <= 1'b0;
              end
              state <= S_RESP;
            end
          end
        end
        S_LIMIT: begin
          limit <= FC_W'((total_bars == '0) ? BARS_ZERO : total_bars) * FC_W'(fpb);
          state <= S_CHECK;
        end
        S_CHECK: begin
          if (finished || frame_count >= limit) begin
            finished <= 1'b1;
            pend     <= '{left_sample: '0, right_sample: '0, frame_valid: 1'b1,
                          done_res: 1'b1};
            state    <= S_RESP;
          end else begin
            cnt   <= '0;
            acc_l <= '0;
            acc_r <= '0;
            state <= S_SWEEP;
          end
        end
        S_SWEEP: begin
          if (!issue_done) begin
            cnt <= cnt + 1'b1;
          end
          if (vf) begin
            acc_l <= acc_l + (en0_f ? ACC_W'(sram_rdata_a) : '0);
            acc_r <= acc_r + (en1_f ? ACC_W'(sram_rdata_b) : '0);
          end
          // drained: all stages empty after the last issue
          if (issue_done && !vb && !vc && !vd && !ve && !vf) begin
            pend        <= '{left_sample: sat16(acc_l), right_sample: sat16(acc_r),
                             frame_valid: 1'b1, done_res: 1'b0};
            frame_count <= frame_count + 1'b1;
            state       <= S_RESP;
          end
        end
        S_RESP: begin
          if (load_res) begin
            res_data <= pend;
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_sweep_bound: assert property (@(posedge clk) disable iff (rst)
    state == S_SWEEP |-> cnt <= (ENTRY_W+1)'(ENTRIES))
    else $error("sweep counter ran past the block table");

  a_write_idle: assert property (@(posedge clk) disable iff (rst)
    (sram_we || blk_we) |-> state == S_IDLE)
    else $error("memory write outside idle");

  a_acc_sweep: assert property (@(posedge clk) disable iff (rst)
    vf |-> state == S_SWEEP)
    else $error("accumulate stage active outside a sweep");

  a_finish_src: assert property (@(posedge clk) disable iff (rst)
    $rose(finished) |-> $past(state) == S_CHECK)
    else $error("finished raised outside the end check");
`endif

endmodule

@@ rtl/core/psm_ram.sv @@
// ----------------------------------------------------------------------------
// psm_ram
// Generic RAM: one write port, two read ports, registered read data.
// ----------------------------------------------------------------------------
module psm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  output logic [WIDTH-1:0]         rdata_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

@@ tb/pattern_sample_mixer_core_tb.sv @@
// ----------------------------------------------------------------------------
// pattern_sample_mixer_core_tb
// Self-checking bench for the frame sequencer and mixer. Requests load sample
// words, pattern blocks and layer info, restart playback and tick frames. A
// behavioral mixer in the bench predicts every result; a monitor compares each
// result field by field in order. Frame length and playback length are swept
// over several settings, extremes included, through the config port.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module pattern_sample_mixer_core_tb;
  import psm_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int LONG_HOLD      = 400;
  localparam int PHASE_ITEMS    = 90;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        req_valid = 1'b0;
  logic        req_ready;
  req_t        req_data = '0;
  logic        res_valid;
  logic        res_ready = 1'b0;
  res_t        res_data;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  pattern_sample_mixer_core u_top (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
    .res_valid(res_valid), .res_ready(res_ready), .res_data(res_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #5 clk = ~clk;

  // mixer state mirrored in the bench
  logic [23:0]              mix_fpb = FPB_RESET;
  logic [12:0]              mix_bars = BARS_RESET;
  logic [FC_W-1:0]          frame_pos = '0;
  bit                       play_done = 1'b0;
  logic signed [15:0]       sample_mem [int];
  blk_t                     blk_tab [LAYERS*BLOCKS_PER_LAYER];
  int                       lyr_words [LAYERS];
  int                       lyr_chans [LAYERS];
  int                       unwritten_q [$];

  req_t pend_req_q [$];
  res_t exp_frame_q [$];

  int  fail_cnt = 0;
  int  res_cnt = 0;
  int  burst_left = 0;
  int  gap_left = 0;
  int  hold_left = 0;
  bit  long_hold_done = 1'b0;
  int  stall_mode = 0;
  int  quiet_cycles = 0;

  initial begin
    foreach (blk_tab[i]) blk_tab[i] = '0;
    foreach (lyr_words[i]) begin
      lyr_words[i] = 0;
      lyr_chans[i] = 1;
    end
  end

  function automatic longint unsigned play_end();
    longint unsigned bars;
    bars = (mix_bars == 0) ? 64 : mix_bars;
    return bars * mix_fpb;
  endfunction

  // Sum every active block of every layer at the current frame. In probe mode
  // collect the sample addresses that are read but not yet written.
  task automatic mix_frame(input bit probe, output longint l, output longint r);
    longint unsigned s, e, base, idx;
    int key;
    blk_t bk;
    l = 0;
    r = 0;
    for (int ly = 0; ly < LAYERS; ly++) begin
      if (lyr_words[ly] == 0) continue;
      for (int b = 0; b < BLOCKS_PER_LAYER; b++) begin
        bk = blk_tab[ly*BLOCKS_PER_LAYER + b];
        if (!bk.enable) continue;
        s = longint'(bk.start) * mix_fpb;
        e = (longint'(bk.start) + bk.length) * mix_fpb;
        if (frame_pos < s || frame_pos >= e) continue;
        base = (frame_pos - s) * lyr_chans[ly];
        for (int ch = 0; ch < lyr_chans[ly] && ch < 2; ch++) begin
          idx = base + ch;
          if (idx >= lyr_words[ly]) continue;
          key = ly*SAMPLE_DEPTH + int'(idx);
          if (probe) begin
            if (!sample_mem.exists(key)) unwritten_q.insert(unwritten_q.size(), key);
          end else if (ch == 0) l += sample_mem[key];
          else r += sample_mem[key];
        end
      end
    end
  endtask

  function automatic logic signed [15:0] sat16(input longint v);
    if (v > 32767) return 16'sh7fff;
    if (v < -32768) return 16'sh8000;
    return v[15:0];
  endfunction

  // Advance the mirrored state by one request and return its result.
  task automatic apply_request(input req_t rq, output res_t rs);
    longint l, r;
    int w;
    rs = '0;
    case (rq.req_type)
      REQ_TICK: begin
        rs.frame_valid = 1'b1;
        if (!play_done && frame_pos >= play_end()) play_done = 1'b1;
        if (!play_done) begin
          mix_frame(1'b0, l, r);
          rs.left_sample = sat16(l);
          rs.right_sample = sat16(r);
          frame_pos = frame_pos + 1'b1;
        end
      end
      REQ_SAMPLE: sample_mem[int'(rq.layer)*SAMPLE_DEPTH + int'(rq.address)] = rq.sample_value;
      REQ_BLOCK: begin
        if (int'(rq.address) < BLOCKS_PER_LAYER)
          blk_tab[int'(rq.layer)*BLOCKS_PER_LAYER + int'(rq.address)] =
            '{start: rq.block_start, length: rq.block_length, enable: rq.block_enable};
      end
      REQ_LAYER: begin
        w = int'(rq.layer_words);
        lyr_words[rq.layer] = (w > SAMPLE_DEPTH) ? SAMPLE_DEPTH : w;
        lyr_chans[rq.layer] = (rq.layer_channels == 0) ? 1 : int'(rq.layer_channels);
      end
      REQ_RESTART: begin
        frame_pos = '0;
        play_done = 1'b0;
      end
      default: ;
    endcase
    rs.done_res = play_done;
  endtask

  task automatic queue_req(input req_t rq);
    res_t rs;
    apply_request(rq, rs);
    pend_req_q.insert(pend_req_q.size(), rq);
    exp_frame_q.insert(exp_frame_q.size(), rs);
  endtask

  function automatic req_t noise_req(input logic [2:0] kind);
    req_t rq;
    logic [95:0] noise;
    noise = {$urandom, $urandom, $urandom};
    rq = noise[$bits(req_t)-1:0];
    rq.req_type = kind;
    return rq;
  endfunction

  task automatic queue_sample(input int ly, input int addr, input int val);
    req_t rq;
    rq = noise_req(REQ_SAMPLE);
    rq.layer = 3'(ly);
    rq.address = 16'(addr);
    rq.sample_value = 16'(val);
    queue_req(rq);
  endtask

  task automatic queue_block(input int ly, input int slot, input int st, input int len,
                             input bit en);
    req_t rq;
    rq = noise_req(REQ_BLOCK);
    rq.layer = 3'(ly);
    rq.address = 16'(slot);
    rq.block_start = 12'(st);
    rq.block_length = 12'(len);
    rq.block_enable = en;
    queue_req(rq);
  endtask

  task automatic queue_layer(input int ly, input int words, input int chans);
    req_t rq;
    rq = noise_req(REQ_LAYER);
    rq.layer = 3'(ly);
    rq.layer_words = 17'(words);
    rq.layer_channels = 2'(chans);
    queue_req(rq);
  endtask

  // Write any sample word the tick would read before it was ever written.
  task automatic queue_tick();
    longint l, r;
    unwritten_q.delete();
    if (!play_done && frame_pos < play_end()) mix_frame(1'b1, l, r);
    foreach (unwritten_q[i])
      if (!sample_mem.exists(unwritten_q[i]))
        queue_sample(unwritten_q[i] / SAMPLE_DEPTH, unwritten_q[i] % SAMPLE_DEPTH, $urandom);
    queue_req(noise_req(REQ_TICK));
  endtask

  task automatic queue_random();
    int pick;
    int words;
    pick = $urandom_range(0, 99);
    if (pick < 45) queue_tick();
    else if (pick < 65) queue_sample($urandom, $urandom, $urandom);
    else if (pick < 78)
      queue_block($urandom, ($urandom_range(0, 6) != 0) ? $urandom_range(0, 15) : $urandom,
                  ($urandom_range(0, 3) != 0) ? $urandom_range(0, 3) : $urandom,
                  ($urandom_range(0, 3) != 0) ? $urandom_range(0, 4) : $urandom,
                  $urandom_range(0, 4) != 0);
    else if (pick < 87) begin
      case ($urandom_range(0, 5))
        0: words = 0;
        1: words = SAMPLE_DEPTH;
        2: words = $urandom_range(SAMPLE_DEPTH + 1, 131071);
        default: words = $urandom_range(1, 64);
      endcase
      queue_layer($urandom, words, $urandom_range(0, 3));
    end else if (pick < 93) queue_req(noise_req(REQ_RESTART));
    else queue_req(noise_req(3'($urandom_range(5, 7))));
  endtask

  task automatic wait_idle();
    while (pend_req_q.size() != 0 || req_valid || exp_frame_q.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic cfg_write(input logic reg_idx, input logic [31:0] value);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {reg_idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (reg_idx == REG_FPB) mix_fpb = value[23:0];
    else mix_bars = value[12:0];
  endtask

  task automatic report(input string what, input int got, input int want);
    $display("mismatch at result %0d: %s got %0d expected %0d", res_cnt, what, got, want);
    fail_cnt++;
  endtask

  // Drive requests in bursts with random gaps.
  always @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else if (!req_valid || req_ready) begin
      if (gap_left > 0) begin
        gap_left--;
        req_valid <= 1'b0;
      end else if (pend_req_q.size() != 0) begin
        req_data <= pend_req_q.pop_front();
        req_valid <= 1'b1;
        if (burst_left <= 1) begin
          burst_left = $urandom_range(1, 16);
          gap_left = $urandom_range(0, 1) ? 0 : $urandom_range(1, 6);
        end else burst_left--;
      end else begin
        req_valid <= 1'b0;
      end
    end
  end

  // Check results and stall the result channel on a pattern of its own.
  always @(posedge clk) begin
    res_t want;
    if (rst) begin
      res_ready <= 1'b0;
    end else begin
      if (res_valid && res_ready) begin
        if (exp_frame_q.size() == 0) begin
          report("unexpected result", 1, 0);
        end else begin
          want = exp_frame_q.pop_front();
          if (res_data.left_sample !== want.left_sample)
            report("left", res_data.left_sample, want.left_sample);
          if (res_data.right_sample !== want.right_sample)
            report("right", res_data.right_sample, want.right_sample);
          if (res_data.frame_valid !== want.frame_valid)
            report("frame_valid", res_data.frame_valid, want.frame_valid);
          if (res_data.done_res !== want.done_res)
            report("done", res_data.done_res, want.done_res);
        end
        res_cnt++;
      end
      if (!long_hold_done && res_cnt >= 300) begin
        long_hold_done = 1'b1;
        hold_left = LONG_HOLD;
      end
      if ($urandom_range(0, 63) == 0) stall_mode = $urandom_range(0, 2);
      if (hold_left > 0) begin
        hold_left--;
        res_ready <= 1'b0;
      end else begin
        case (stall_mode)
          0: res_ready <= 1'b1;
          1: res_ready <= 1'($urandom_range(0, 1));
          default: res_ready <= ($urandom_range(0, 7) != 0);
        endcase
      end
    end
  end

  // End the run when nothing moves for too long.
  always @(posedge clk) begin
    if ((req_valid && req_ready) || (res_valid && res_ready) || psel || rst)
      quiet_cycles <= 0;
    else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("** pattern_sample_mixer_core: FAILED **");
      $finish;
    end else quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    int fpb_set [7];
    int bars_set [7];
    fpb_set  = '{1, 0, 3, 16777215, 2, 4, 88200};
    bars_set = '{1, 7, 0, 4096, 3, 2, 64};
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // directed: layer formats, block slot edges, saturation, odd requests
    queue_sample(0, 0, 32767);
    queue_sample(0, 1, -32768);
    queue_sample(7, 65535, -1);
    queue_layer(0, 4, 2);
    queue_layer(1, SAMPLE_DEPTH, 1);
    queue_layer(2, 131071, 3);
    queue_layer(3, 8, 0);
    queue_block(0, 0, 0, 1, 1'b1);
    queue_block(0, 1, 0, 4095, 1'b1);
    queue_block(0, 15, 0, 2, 1'b1);
    queue_block(0, 16, 0, 2, 1'b1);
    queue_block(1, 0, 4095, 4095, 1'b1);
    queue_block(2, 3, 0, 1, 1'b1);
    queue_block(3, 0, 0, 1, 1'b0);
    queue_tick();
    queue_tick();
    queue_req(noise_req(3'd5));
    queue_req(noise_req(3'd7));
    queue_req(noise_req(REQ_RESTART));
    queue_tick();
    for (int i = 0; i < PHASE_ITEMS; i++) queue_random();

    // sweep frame and playback length, pausing until all results are in
    foreach (fpb_set[p]) begin
      wait_idle();
      cfg_write(REG_FPB, fpb_set[p]);
      cfg_write(REG_BARS, bars_set[p]);
      queue_req(noise_req(REQ_RESTART));
      for (int i = 0; i < PHASE_ITEMS; i++) queue_random();
    end

    wait_idle();
    repeat (200) @(posedge clk);
    if (fail_cnt == 0 && exp_frame_q.size() == 0)
      $display("** pattern_sample_mixer_core: PASSED **");
    else
      $display("** pattern_sample_mixer_core: FAILED **");
    $finish;
  end

endmodule
